/* hdl/pia_pkg.sv */
// shared constants, codes and types of the power iteration block
package pia_pkg;

    localparam int DIM       = 16;
    localparam int IDX_W     = $clog2(DIM);
    localparam int SIZE_W    = IDX_W + 1;
    localparam int MAT_DEPTH = DIM * DIM;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int BANK_W    = 2;
    localparam int VEC_DEPTH = 4 * DIM;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NORM_W    = 31;
    localparam int ITER_W    = 16;
    localparam int ACC_W     = 64;
    localparam int ROOT_W    = ACC_W / 2;
    localparam int DIV_NUM_W = DATA_W + FRAC_BITS;

    localparam logic [1:0] CMD_LOAD_MAT = 2'd0;
    localparam logic [1:0] CMD_LOAD_VEC = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] REG_ROUND_LIMIT = 2'd0;
    localparam logic [1:0] REG_TOL         = 2'd1;
    localparam logic [1:0] REG_SIZE        = 2'd2;

    localparam logic [BANK_W-1:0] BANK_START = 2'd0;
    localparam logic [BANK_W-1:0] BANK_PROD  = 2'd1;
    localparam logic [BANK_W-1:0] BANK_UNIT  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NS_RD,
        ST_NS_MUL,
        ST_NS_ACC,
        ST_SQRT,
        ST_NM_RD,
        ST_NM_DIV,
        ST_NM_WAIT,
        ST_ROUND,
        ST_MV_RD,
        ST_MV_MUL,
        ST_MV_ACC,
        ST_MV_WR,
        ST_MV_SQ,
        ST_MV_SQA,
        ST_DONE
    } state_t;

endpackage

/* hdl/power_iteration_eigenvalue.sv */
// top level: power iteration for the dominant eigenvalue magnitude
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: row, col, value; tuser: cmd
// m_        out  m_tvalid/m_tready  tdata: eigenvalue, rounds_used, last_difference;
//                                   tuser: converged, zero_vector
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// load items are accepted back to back while the block is idle
// a start item keeps the block busy for the start norm and its normalization,
// then for each round of A*q, norm and normalize, waiting on the iterative
// square root and divide units in turn
// s_tready is low from a start item until its result sits in the output register
// a result waits in the output register while loads go on; a stalled m_ side
// only holds the block once the next start item finishes
// reset is synchronous; matrix and vector memories are not cleared
module power_iteration_eigenvalue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic [1:0]                  s_tuser,   // cmd[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,   // eigenvalue[30:0], rounds_used[46:31],
                                                   // last_difference[77:47], zero pad
    output logic [1:0]                  m_tuser,   // converged[0], zero_vector[1]
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [30:0]                 cfg_wdata
);

    localparam int DW = pia_pkg::DATA_W;
    localparam int NW = pia_pkg::NORM_W;
    localparam int IW = pia_pkg::IDX_W;
    localparam int AW = pia_pkg::ACC_W;

    // configuration registers
    logic [pia_pkg::ITER_W-1:0] round_limit_reg;
    logic [NW-1:0]              tol_reg;
    logic [pia_pkg::SIZE_W-1:0] size_reg;

    // sequencer state
    pia_pkg::state_t            state_reg, state_next;
    logic [pia_pkg::SIZE_W-1:0] n_reg, n_next;
    logic [IW-1:0]              i_reg, i_next;
    logic [IW-1:0]              j_reg, j_next;
    logic                       in_round_reg, in_round_next;
    logic [pia_pkg::BANK_W-1:0] src_reg, src_next;

    // datapath registers
    logic signed [AW-1:0]       prod_reg;
    logic [AW-1:0]              sumsq_reg, sumsq_next;
    logic signed [AW-1:0]       dacc_reg, dacc_next;
    logic signed [DW-1:0]       x_reg, x_next;
    logic [NW-1:0]              cur_reg, cur_next;
    logic [NW-1:0]              prev_reg, prev_next;
    logic [NW-1:0]              diff_reg, diff_next;
    logic [NW-1:0]              eig_reg, eig_next;
    logic [pia_pkg::ITER_W-1:0] rc_reg, rc_next;
    logic                       conv_reg, conv_next;
    logic                       zero_reg, zero_next;

    // output register
    logic                       m_valid_reg;
    logic [79:0]                m_data_reg;
    logic [1:0]                 m_user_reg;
    logic                       out_load;

    // memories
    logic                       mat_we;
    logic [pia_pkg::MAT_AW-1:0] mat_waddr, mat_raddr;
    logic [DW-1:0]              mat_rdata;
    logic                       vec_we;
    logic [pia_pkg::VEC_AW-1:0] vec_waddr, vec_raddr;
    logic [DW-1:0]              vec_wdata, vec_rdata;

    // shared multiplier
    logic signed [DW-1:0]       mul_a, mul_b;

    // arithmetic units
    logic                       sqrt_start, div_start;
    logic [pia_pkg::ROOT_W-1:0] root;
    logic signed [DW-1:0]       quot;
    logic signed [DW-1:0]       div_dividend;
    pia_pkg::unit_status_t      sqrt_st, div_st;

    // combinational helpers
    logic                       s_acc;
    logic [IW-1:0]              s_row, s_col;
    logic [DW-1:0]              s_value;
    logic [1:0]                 s_cmd;
    logic [pia_pkg::SIZE_W-1:0] n_last;
    logic                       i_last, j_last;
    logic [AW:0]                sq_sum;
    logic [AW-1:0]              sq_sat;
    logic signed [AW:0]         d_sum;
    logic signed [AW-1:0]       d_sat;
    logic signed [AW-1:0]       d_shift;
    logic signed [DW-1:0]       x_sat;
    logic [NW-1:0]              norm_w;
    logic [NW-1:0]              diff_w;
    logic [pia_pkg::ITER_W-1:0] rc_inc;

    assign s_row   = s_tdata[3:0];
    assign s_col   = s_tdata[7:4];
    assign s_value = s_tdata[39:8];
    assign s_cmd   = s_tuser;
    assign s_tready = (state_reg == pia_pkg::ST_IDLE);
    assign s_acc   = s_tvalid && s_tready;

    assign n_last = n_reg - 1'b1;
    assign i_last = ({1'b0, i_reg} == n_last);
    assign j_last = ({1'b0, j_reg} == n_last);

    // saturating sum of squares
    assign sq_sum = {1'b0, sumsq_reg} + {1'b0, prod_reg};
    assign sq_sat = sq_sum[AW] ? {AW{1'b1}} : sq_sum[AW-1:0];

    // saturating signed dot product accumulate
    assign d_sum = {dacc_reg[AW-1], dacc_reg} + {prod_reg[AW-1], prod_reg};
    always_comb begin
        if (d_sum[AW] != d_sum[AW-1]) begin
            d_sat = d_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            d_sat = d_sum[AW-1:0];
        end
    end

    // floor shift and saturate to 32 bits
    assign d_shift = dacc_reg >>> pia_pkg::FRAC_BITS;
    always_comb begin
        if ((&d_shift[AW-1:DW-1]) || !(|d_shift[AW-1:DW-1])) begin
            x_sat = d_shift[DW-1:0];
        end else begin
            x_sat = d_shift[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign norm_w = root[pia_pkg::ROOT_W-1] ? {NW{1'b1}} : root[NW-1:0];
    assign diff_w = (prev_reg > norm_w) ? prev_reg - norm_w : norm_w - prev_reg;
    assign rc_inc = in_round_reg ? rc_reg + 1'b1 : rc_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_limit_reg <= pia_pkg::ITER_W'(1000);
            tol_reg         <= NW'(66);
            size_reg        <= pia_pkg::SIZE_W'(pia_pkg::DIM);
        end else if (cfg_we) begin
            case (cfg_index)
                pia_pkg::REG_ROUND_LIMIT: round_limit_reg <= cfg_wdata[pia_pkg::ITER_W-1:0];
                pia_pkg::REG_TOL:         tol_reg         <= cfg_wdata;
                pia_pkg::REG_SIZE:        size_reg        <= cfg_wdata[pia_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pia_pkg::ST_IDLE;
            in_round_reg <= 1'b0;
            conv_reg     <= 1'b0;
            zero_reg     <= 1'b0;
            rc_reg       <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            in_round_reg <= in_round_next;
            conv_reg     <= conv_next;
            zero_reg     <= zero_next;
            rc_reg       <= rc_next;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        src_reg   <= src_next;
        sumsq_reg <= sumsq_next;
        dacc_reg  <= dacc_next;
        x_reg     <= x_next;
        diff_reg  <= diff_next;
        eig_reg   <= eig_next;
        prod_reg  <= AW'(mul_a) * AW'(mul_b);
    end

    // next state and datapath control
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        src_next      = src_reg;
        in_round_next = in_round_reg;
        sumsq_next    = sumsq_reg;
        dacc_next     = dacc_reg;
        x_next        = x_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        diff_next     = diff_reg;
        eig_next      = eig_reg;
        rc_next       = rc_reg;
        conv_next     = conv_reg;
        zero_next     = zero_reg;
        mat_we        = 1'b0;
        mat_waddr     = {s_row, s_col};
        mat_raddr     = {i_reg, j_reg};
        vec_we        = 1'b0;
        vec_waddr     = {pia_pkg::BANK_START, s_row};
        vec_wdata     = s_value;
        vec_raddr     = {src_reg, i_reg};
        mul_a         = vec_rdata;
        mul_b         = vec_rdata;
        sqrt_start    = 1'b0;
        div_start     = 1'b0;
        div_dividend  = vec_rdata;
        out_load      = 1'b0;

        case (state_reg)
            pia_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (s_cmd)
                        pia_pkg::CMD_LOAD_MAT: mat_we = 1'b1;
                        pia_pkg::CMD_LOAD_VEC: vec_we = 1'b1;
                        pia_pkg::CMD_START: begin
                            // clamp size to 1..DIM
                            if (size_reg > pia_pkg::SIZE_W'(pia_pkg::DIM)) begin
                                n_next = pia_pkg::SIZE_W'(pia_pkg::DIM);
                            end else if (size_reg == '0) begin
                                n_next = pia_pkg::SIZE_W'(1);
                            end else begin
                                n_next = size_reg;
                            end
                            i_next        = '0;
                            src_next      = pia_pkg::BANK_START;
                            sumsq_next    = '0;
                            in_round_next = 1'b0;
                            conv_next     = 1'b0;
                            zero_next     = 1'b0;
                            diff_next     = '0;
                            rc_next       = '0;
                            state_next    = pia_pkg::ST_NS_RD;
                        end
                        default: ;
                    endcase
                end
            end
            pia_pkg::ST_NS_RD: begin
                state_next = pia_pkg::ST_NS_MUL;
            end
            pia_pkg::ST_NS_MUL: begin
                state_next = pia_pkg::ST_NS_ACC;
            end
            pia_pkg::ST_NS_ACC: begin
                sumsq_next = sq_sat;
                if (i_last) begin
                    sqrt_start = 1'b1;
                    state_next = pia_pkg::ST_SQRT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = pia_pkg::ST_NS_RD;
                end
            end
            pia_pkg::ST_SQRT: begin
                if (sqrt_st.done) begin
                    cur_next = norm_w;
                    eig_next = norm_w;
                    i_next   = '0;
                    src_next = pia_pkg::BANK_PROD;
                    if (!in_round_reg) begin
                        prev_next = norm_w;
                        src_next  = pia_pkg::BANK_START;
                        if (norm_w == '0) begin
                            zero_next  = 1'b1;
                            state_next = pia_pkg::ST_DONE;
                        end else begin
                            state_next = pia_pkg::ST_NM_RD;
                        end
                    end else begin
                        diff_next = diff_w;
                        if (diff_w < tol_reg) begin
                            conv_next  = 1'b1;
                            state_next = pia_pkg::ST_DONE;
                        end else if (norm_w == '0) begin
                            zero_next  = 1'b1;
                            state_next = pia_pkg::ST_DONE;
                        end else begin
                            state_next = pia_pkg::ST_NM_RD;
                        end
                    end
                end
            end
            pia_pkg::ST_NM_RD: begin
                state_next = pia_pkg::ST_NM_DIV;
            end
            pia_pkg::ST_NM_DIV: begin
                div_start  = 1'b1;
                state_next = pia_pkg::ST_NM_WAIT;
            end
            pia_pkg::ST_NM_WAIT: begin
                vec_waddr = {pia_pkg::BANK_UNIT, i_reg};
                vec_wdata = quot;
                if (div_st.done) begin
                    vec_we = 1'b1;
                    if (!i_last) begin
                        i_next     = i_reg + 1'b1;
                        state_next = pia_pkg::ST_NM_RD;
                    end else begin
                        // a finished normalization closes a round; the start normalization counts none
                        rc_next       = rc_inc;
                        in_round_next = 1'b1;
                        if (rc_inc < round_limit_reg) begin
                            state_next = pia_pkg::ST_ROUND;
                        end else begin
                            state_next = pia_pkg::ST_DONE;
                        end
                    end
                end
            end
            pia_pkg::ST_ROUND: begin
                prev_next  = cur_reg;
                i_next     = '0;
                j_next     = '0;
                dacc_next  = '0;
                sumsq_next = '0;
                state_next = pia_pkg::ST_MV_RD;
            end
            pia_pkg::ST_MV_RD: begin
                vec_raddr  = {pia_pkg::BANK_UNIT, j_reg};
                state_next = pia_pkg::ST_MV_MUL;
            end
            pia_pkg::ST_MV_MUL: begin
                mul_a      = mat_rdata;
                state_next = pia_pkg::ST_MV_ACC;
            end
            pia_pkg::ST_MV_ACC: begin
                dacc_next = d_sat;
                if (j_last) begin
                    state_next = pia_pkg::ST_MV_WR;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = pia_pkg::ST_MV_RD;
                end
            end
            pia_pkg::ST_MV_WR: begin
                vec_we     = 1'b1;
                vec_waddr  = {pia_pkg::BANK_PROD, i_reg};
                vec_wdata  = x_sat;
                x_next     = x_sat;
                state_next = pia_pkg::ST_MV_SQ;
            end
            pia_pkg::ST_MV_SQ: begin
                mul_a      = x_reg;
                mul_b      = x_reg;
                state_next = pia_pkg::ST_MV_SQA;
            end
            pia_pkg::ST_MV_SQA: begin
                sumsq_next = sq_sat;
                if (i_last) begin
                    sqrt_start = 1'b1;
                    state_next = pia_pkg::ST_SQRT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    j_next     = '0;
                    dacc_next  = '0;
                    state_next = pia_pkg::ST_MV_RD;
                end
            end
            pia_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = pia_pkg::ST_IDLE;
                end
            end
            default: state_next = pia_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {2'b00, diff_reg, rc_reg, zero_reg ? {NW{1'b0}} : eig_reg};
            m_user_reg <= {zero_reg, conv_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // matrix memory, row-major
    pia_ram #(
        .DEPTH (pia_pkg::MAT_DEPTH),
        .WIDTH (DW)
    ) u_mat_ram (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (s_value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // vector memory: start, product and unit banks
    pia_ram #(
        .DEPTH (pia_pkg::VEC_DEPTH),
        .WIDTH (DW)
    ) u_vec_ram (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    pia_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_sat),
        .root     (root),
        .status   (sqrt_st)
    );

    pia_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cur_reg),
        .quotient (quot),
        .status   (div_st)
    );

endmodule

/* hdl/pia_ram.sv */
// simple dual port ram, one write port and one registered read port
module pia_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pia_sqrt.sv */
// iterative floor square root, one result bit per cycle
module pia_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pia_pkg::ACC_W-1:0]    radicand,
    output logic [pia_pkg::ROOT_W-1:0]   root,
    output pia_pkg::unit_status_t        status
);

    localparam int REM_W = pia_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(pia_pkg::ROOT_W);

    logic [pia_pkg::ACC_W-1:0]  rad_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [pia_pkg::ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [REM_W-1:0]           rem_sh;
    logic [REM_W-1:0]           trial;
    logic                       fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[pia_pkg::ACC_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[pia_pkg::ACC_W-3:0], 2'b00};
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[pia_pkg::ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pia_pkg::ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/pia_div.sv */
// iterative signed fixed point divide by a positive norm, saturated
module pia_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [pia_pkg::DATA_W-1:0]  dividend,
    input  logic [pia_pkg::NORM_W-1:0]         divisor,
    output logic signed [pia_pkg::DATA_W-1:0]  quotient,
    output pia_pkg::unit_status_t              status
);

    localparam int NW    = pia_pkg::DIV_NUM_W;
    localparam int DW    = pia_pkg::DATA_W;
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]              num_reg;
    logic [NW-1:0]              q_reg;
    logic [DW-1:0]              rem_reg;
    logic [pia_pkg::NORM_W-1:0] div_reg;
    logic                       neg_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DW-1:0]              mag;
    logic [DW-1:0]              rem_sh;
    logic                       fits;
    logic                       q_hi;

    assign mag    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign rem_sh = {rem_reg[DW-2:0], num_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= {mag, {pia_pkg::FRAC_BITS{1'b0}}};
                q_reg    <= '0;
                rem_reg  <= '0;
                div_reg  <= divisor;
                neg_reg  <= dividend[DW-1];
            end else if (busy_reg) begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                rem_reg <= fits ? rem_sh - {1'b0, div_reg} : rem_sh;
                q_reg   <= {q_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // saturate the magnitude quotient to signed 32 bits
    assign q_hi = |q_reg[NW-1:DW];
    always_comb begin
        if (!neg_reg) begin
            quotient = (q_hi || q_reg[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : q_reg[DW-1:0];
        end else if (q_hi || (q_reg[DW-1] && |q_reg[DW-2:0])) begin
            quotient = {1'b1, {(DW-1){1'b0}}};
        end else begin
            quotient = -q_reg[DW-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/pia_checker.sv */
// port level checks of the power iteration block and their bind
module pia_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed under stall");

    // a start item makes the block busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pia_pkg::CMD_START) |=> !s_tready)
        else $error("input taken right after a start item");

    // converged and zero vector never come together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("converged and zero vector both set");

    // a zero vector result reports eigenvalue zero
    a_zero_eig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[30:0] == 31'd0))
        else $error("zero vector result with nonzero eigenvalue");

endmodule

bind power_iteration_eigenvalue pia_checker u_pia_checker (.*);

/* tb/tb_power_iteration_eigenvalue.sv */
// self-checking testbench for the power iteration eigenvalue block
module tb_power_iteration_eigenvalue;

    typedef struct {
        logic [30:0] eigenvalue;
        logic        converged;
        logic [15:0] rounds_used;
        logic [30:0] last_difference;
        logic        zero_vector;
    } eig_result_t;

    // own copy of the block state, predicts one result per start item
    class eig_scoreboard;
        int          mat_mem [pia_pkg::DIM*pia_pkg::DIM];
        int          start_vec [pia_pkg::DIM];
        int          prod_vec [pia_pkg::DIM];
        int          unit_vec [pia_pkg::DIM];
        int unsigned round_limit;
        int unsigned tol;
        int unsigned size_reg;
        eig_result_t pending_q [$];
        int          errors;
        int          results_seen;
        int          converged_seen;
        int          zero_seen;

        function new();
            round_limit = 1000;
            tol         = 66;
            size_reg    = 16;
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] val);
            case (idx)
                pia_pkg::REG_ROUND_LIMIT: round_limit = {16'd0, val[15:0]};
                pia_pkg::REG_TOL:         tol         = {1'b0, val[30:0]};
                pia_pkg::REG_SIZE:        size_reg    = {27'd0, val[4:0]};
                default: ;
            endcase
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return int'(v);
        endfunction

        // floor isqrt of saturating sum of squares, clipped to 31 bits
        function int unsigned vec_norm(int v [pia_pkg::DIM], int n);
            logic [63:0] acc, sq, rem, res, b;
            acc = 0;
            for (int i = 0; i < n; i++) begin
                sq = longint'(v[i]) * longint'(v[i]);
                acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
            end
            rem = acc;
            res = 0;
            b = 64'd1 << 62;
            while (b > rem) b = b >> 2;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return (res > 64'h7FFFFFFF) ? 32'h7FFFFFFF : int'(res[31:0]);
        endfunction

        function void scale_to_unit(int n, int unsigned beta);
            longint num;
            for (int i = 0; i < n; i++) begin
                num = longint'(prod_vec[i]) * 64'sd65536;
                unit_vec[i] = clamp32(num / longint'(beta));
            end
        endfunction

        function void mat_times_unit(int n);
            longint acc, p;
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++) begin
                    p = longint'(mat_mem[i*pia_pkg::DIM+j]) * longint'(unit_vec[j]);
                    if (p > 0 && acc > 64'sh7FFFFFFFFFFFFFFF - p)
                        acc = 64'sh7FFFFFFFFFFFFFFF;
                    else if (p < 0 && acc < 64'sh8000000000000000 - p)
                        acc = 64'sh8000000000000000;
                    else
                        acc = acc + p;
                end
                prod_vec[i] = clamp32(acc >>> pia_pkg::FRAC_BITS);
            end
        endfunction

        function eig_result_t run_iteration();
            eig_result_t r;
            int          n;
            int unsigned cur, prev, diff, rc, eig;
            n = size_reg;
            if (n > pia_pkg::DIM) n = pia_pkg::DIM;
            if (n == 0) n = 1;
            prod_vec = start_vec;
            cur = vec_norm(prod_vec, n);
            rc = 0; diff = 0; eig = 0;
            r.converged = 0;
            r.zero_vector = 0;
            if (cur == 0) begin
                r.zero_vector = 1;
            end else begin
                scale_to_unit(n, cur);
                eig = cur;
                for (int unsigned k = 0; k < round_limit; k++) begin
                    prev = cur;
                    mat_times_unit(n);
                    cur = vec_norm(prod_vec, n);
                    diff = (prev > cur) ? prev - cur : cur - prev;
                    eig = cur;
                    if (diff < tol) begin
                        r.converged = 1;
                        break;
                    end
                    if (cur == 0) begin
                        r.zero_vector = 1;
                        eig = 0;
                        break;
                    end
                    scale_to_unit(n, cur);
                    rc = k + 1;
                end
            end
            r.eigenvalue      = eig[30:0];
            r.rounds_used     = rc[15:0];
            r.last_difference = diff[30:0];
            return r;
        endfunction

        function void note_item(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
                                logic [31:0] val);
            case (cmd)
                pia_pkg::CMD_LOAD_MAT: mat_mem[row*pia_pkg::DIM+col] = val;
                pia_pkg::CMD_LOAD_VEC: start_vec[row] = val;
                pia_pkg::CMD_START:    pending_q.push_back(run_iteration());
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [79:0] data, logic [1:0] user);
            eig_result_t e;
            results_seen++;
            if (pending_q.size() == 0) begin
                report("result with no expectation");
                return;
            end
            e = pending_q.pop_front();
            if (e.converged) converged_seen++;
            if (e.zero_vector) zero_seen++;
            if (data[30:0] !== e.eigenvalue)
                report($sformatf("eigenvalue %0d exp %0d", data[30:0], e.eigenvalue));
            if (data[46:31] !== e.rounds_used)
                report($sformatf("rounds_used %0d exp %0d", data[46:31], e.rounds_used));
            if (data[77:47] !== e.last_difference)
                report($sformatf("last_difference %0d exp %0d", data[77:47],
                                 e.last_difference));
            if (user[0] !== e.converged)
                report($sformatf("converged %0b exp %0b", user[0], e.converged));
            if (user[1] !== e.zero_vector)
                report($sformatf("zero_vector %0b exp %0b", user[1], e.zero_vector));
        endtask
    endclass

    localparam int QUIET_LIMIT = 100000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_wdata = '0;

    eig_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int n_eff;

    power_iteration_eigenvalue u_top (.*);

    always #5 aclk = ~aclk;

    // receiver: random backpressure by phase
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= rx_stall_pct);

    // result monitor and watchdog on no-progress cycles
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         sb.pending_q.size());
                $display("tb_power_iteration_eigenvalue: errors");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
                             logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {val, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(cmd, row, col, val);
        items_sent++;
        @(negedge aclk);
    endtask

    // drain outstanding results, then let the block finish before a register write
    task automatic settle();
        s_tvalid <= 0;
        @(negedge aclk);
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1, 2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h20000)
                                              : -$urandom_range(0, 32'h20000);
            3: return 0;
            4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom_range(0, 3) << 16;
        endcase
    endfunction

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // fill every entry so no start ever reads an unwritten one
        for (int r = 0; r < pia_pkg::DIM; r++)
            for (int c = 0; c < pia_pkg::DIM; c++)
                send_item(pia_pkg::CMD_LOAD_MAT, 4'(r), 4'(c),
                          (r == c) ? 32'h10000 : 32'h0);
        for (int r = 0; r < pia_pkg::DIM; r++)
            send_item(pia_pkg::CMD_LOAD_VEC, 4'(r), 4'd0, $urandom_range(1, 32'h40000));

        // directed: identity matrix converges under reset settings
        send_item(pia_pkg::CMD_RESERVED, 4'hF, 4'hF, $urandom);
        send_item(pia_pkg::CMD_START, 4'd0, 4'd0, 32'd0);
        settle();
        // no rounds, size zero acts as one, most negative start element
        write_reg(pia_pkg::REG_ROUND_LIMIT, 31'd0);
        write_reg(pia_pkg::REG_SIZE, 31'd0);
        send_item(pia_pkg::CMD_LOAD_VEC, 4'd0, 4'd0, 32'h80000000);
        send_item(pia_pkg::CMD_START, 4'd0, 4'd0, 32'd0);
        settle();
        // zero product under the largest round limit, zero tolerance
        write_reg(pia_pkg::REG_ROUND_LIMIT, 31'hFFFF);
        write_reg(pia_pkg::REG_TOL, 31'd0);
        write_reg(pia_pkg::REG_SIZE, 31'd1);
        send_item(pia_pkg::CMD_LOAD_MAT, 4'd0, 4'd0, 32'd0);
        send_item(pia_pkg::CMD_START, 4'd0, 4'd0, 32'd0);
        // zero start vector
        send_item(pia_pkg::CMD_LOAD_VEC, 4'd0, 4'd0, 32'd0);
        send_item(pia_pkg::CMD_START, 4'd0, 4'd0, 32'd0);
        settle();
        // size above the dimension, widest tolerance, extreme elements
        write_reg(pia_pkg::REG_ROUND_LIMIT, 31'd3);
        write_reg(pia_pkg::REG_TOL, 31'h7FFFFFFF);
        write_reg(pia_pkg::REG_SIZE, 31'd31);
        send_item(pia_pkg::CMD_LOAD_MAT, 4'hF, 4'hF, 32'h7FFFFFFF);
        send_item(pia_pkg::CMD_LOAD_MAT, 4'd0, 4'd0, 32'h80000000);
        send_item(pia_pkg::CMD_LOAD_VEC, 4'hF, 4'd0, 32'h7FFFFFFF);
        send_item(pia_pkg::CMD_START, 4'd0, 4'd0, 32'd0);
        settle();
        write_reg(pia_pkg::REG_ROUND_LIMIT, 31'd4);
        write_reg(pia_pkg::REG_TOL, 31'd66);
        write_reg(pia_pkg::REG_SIZE, 31'd2);
        send_item(pia_pkg::CMD_LOAD_MAT, 4'd0, 4'd1, 32'h7FFFFFFF);
        send_item(pia_pkg::CMD_LOAD_MAT, 4'd1, 4'd0, 32'h80000000);
        send_item(pia_pkg::CMD_LOAD_VEC, 4'd0, 4'd0, 32'h10000);
        send_item(pia_pkg::CMD_START, 4'd0, 4'd0, 32'd0);
        settle();

        // random phases: idle patterns times several register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            for (int st = 0; st < 3; st++) begin
                int unsigned it, tl, sz, r;
                it = $urandom_range(0, 12);
                case ($urandom_range(3))
                    0: tl = 0;
                    1: tl = $urandom_range(0, 32'h100000);
                    2: tl = $urandom & 32'h7FFFFFFF;
                    default: tl = 32'h7FFFFFFF;
                endcase
                if ($urandom_range(3) == 0) begin
                    sz = $urandom_range(16, 31);
                    if (it > 3) it = 3;
                end else begin
                    sz = $urandom_range(0, 5);
                end
                write_reg(pia_pkg::REG_ROUND_LIMIT, 31'(it));
                write_reg(pia_pkg::REG_TOL, 31'(tl));
                write_reg(pia_pkg::REG_SIZE, 31'(sz));
                n_eff = (sz > pia_pkg::DIM) ? pia_pkg::DIM : (sz == 0) ? 1 : sz;
                for (int i = 0; i < 85; i++) begin
                    r = $urandom_range(99);
                    if (r < 8)
                        send_item(pia_pkg::CMD_START, 4'($urandom), 4'($urandom),
                                  $urandom);
                    else if (r < 10)
                        send_item(pia_pkg::CMD_RESERVED, 4'($urandom), 4'($urandom),
                                  $urandom);
                    else if (r < 18)
                        send_item(pia_pkg::CMD_LOAD_MAT, 4'($urandom), 4'($urandom),
                                  rand_value());
                    else if (r < 60)
                        send_item(pia_pkg::CMD_LOAD_MAT, 4'($urandom_range(0, n_eff-1)),
                                  4'($urandom_range(0, n_eff-1)), rand_value());
                    else
                        send_item(pia_pkg::CMD_LOAD_VEC, 4'($urandom_range(0, n_eff-1)),
                                  4'($urandom), rand_value());
                end
                settle();
            end
        end

        // last results are in, allow a tail for anything stray
        repeat (200) @(negedge aclk);
        $display("sent %0d items over four idle patterns and %0s", items_sent,
                 "a dozen register settings");
        $display("checked %0d results, %0d converged, %0d with zero norm",
                 sb.results_seen, sb.converged_seen, sb.zero_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_power_iteration_eigenvalue: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors,
                     sb.pending_q.size());
            $display("tb_power_iteration_eigenvalue: errors");
        end
        $finish;
    end
endmodule
